// ----- hw/rtl/qupk_pkg.sv -----
package qupk_pkg;

	// Squared norm of a unit rotation at 16-bit scale.
	localparam logic [31:0] ROOT_BASE = 32'h3fff0001;

	// The radicand never exceeds 32767*32767, so the root has 15 bits.
	localparam int ROOT_STEPS = 15;
	localparam int RAD_W = 2 * ROOT_STEPS;
	localparam int REM_W = ROOT_STEPS + 2;
	localparam int STEP_W = $clog2(ROOT_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// A decoded frame before the sign decision.
	typedef struct packed {
		logic signed [15:0] q0;
		logic signed [15:0] q1;
		logic signed [15:0] q2;
		logic signed [15:0] q3;
		logic               first;
		logic               flip;
	} qupk_frame_t;

endpackage

// ----- hw/rtl/qupk_front.sv -----
module qupk_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [15:0]   comp_a,
	input  logic signed [15:0]   comp_b,
	input  logic signed [15:0]   comp_c,
	input  logic                 simple_mode,
	input  logic                 first_of_track,
	input  logic                 flip,
	output logic                 frame_valid,
	output qupk_pkg::qupk_frame_t frame,
	input  logic                 frame_ready
);
	import qupk_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_SQ, F_PREP, F_ROOT, F_PUSH} fstate_t;

	fstate_t              state_q;
	logic [1:0]           cnt_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [15:0]   a_q, b_q, c_q;
	logic                 simple_q, first_q, flip_q;
	logic [31:0]          sum_q;
	logic [RAD_W-1:0]     rad_q;
	logic [ROOT_STEPS-1:0] root_q;
	logic [REM_W-1:0]     rem_q;

	logic signed [15:0]   sq_op;
	logic signed [31:0]   sq_prod;
	logic [REM_W+1:0]     rem_sh;
	logic [REM_W+1:0]     trial;
	logic [REM_W+1:0]     diff;
	logic                 take;
	logic [15:0]          root_round;

	always_comb begin
		case (cnt_q)
			2'd0:    sq_op = a_q;
			2'd1:    sq_op = simple_q ? 16'sd0 : b_q;
			default: sq_op = simple_q ? 16'sd0 : c_q;
		endcase
	end

	assign sq_prod = sq_op * sq_op;

	// One root digit a cycle: bring down two radicand bits, try 4*root+1.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign take   = (rem_sh >= trial);

	// The remainder r - n*n exceeds n exactly when the root rounds up.
	assign root_round = {1'b0, root_q} +
		16'((rem_q > {{(REM_W-ROOT_STEPS){1'b0}}, root_q}) ? 1 : 0);

	always_comb begin
		frame.q0    = a_q;
		frame.first = first_q;
		frame.flip  = flip_q;
		if (simple_q) begin
			frame.q1 = root_round;
			frame.q2 = 16'sd0;
			frame.q3 = 16'sd0;
		end else begin
			frame.q1 = b_q;
			frame.q2 = c_q;
			frame.q3 = root_round;
		end
	end

	assign full        = (state_q != F_IDLE);
	assign frame_valid = (state_q == F_PUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						a_q      <= comp_a;
						b_q      <= comp_b;
						c_q      <= comp_c;
						simple_q <= simple_mode;
						first_q  <= first_of_track;
						flip_q   <= flip;
						sum_q    <= '0;
						cnt_q    <= '0;
						state_q  <= F_SQ;
					end
				end
				F_SQ: begin
					sum_q <= sum_q + unsigned'(sq_prod);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= F_PREP;
					end
				end
				F_PREP: begin
					rad_q   <= (sum_q < ROOT_BASE) ? RAD_W'(ROOT_BASE - sum_q) : '0;
					root_q  <= '0;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= F_ROOT;
				end
				F_ROOT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					root_q <= {root_q[ROOT_STEPS-2:0], take};
					if (take) begin
						rem_q <= diff[REM_W-1:0];
					end else begin
						rem_q <= rem_sh[REM_W-1:0];
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (frame_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/qupk_fifo.sv -----
module qupk_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  qupk_pkg::qupk_frame_t wr_data,
	output logic                  full,
	input  logic                  rd_en,
	output qupk_pkg::qupk_frame_t rd_data,
	output logic                  empty
);
	import qupk_pkg::*;

	qupk_frame_t        mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr, do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/qupk_back.sv -----
module qupk_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fifo_empty,
	input  qupk_pkg::qupk_frame_t fifo_frame,
	output logic                  fifo_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [15:0]    quat_first,
	output logic signed [15:0]    quat_second,
	output logic signed [15:0]    quat_third,
	output logic signed [15:0]    quat_fourth
);
	import qupk_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_DOT, B_DONE} bstate_t;

	bstate_t            state_q;
	logic [1:0]         cnt_q;
	qupk_frame_t        cur_q;
	logic signed [15:0] prev_q [4];
	logic signed [33:0] dot_q;
	logic               out_valid_q;
	logic signed [15:0] out_q [4];

	logic signed [15:0] cur_comp [4];
	logic signed [31:0] dot_prod;
	logic               negate;
	logic               slot_free;

	assign cur_comp[0] = cur_q.q0;
	assign cur_comp[1] = cur_q.q1;
	assign cur_comp[2] = cur_q.q2;
	assign cur_comp[3] = cur_q.q3;

	assign dot_prod  = cur_comp[cnt_q] * prev_q[cnt_q];
	// The first frame of a track takes its sign from flip alone.
	assign negate    = cur_q.first ? cur_q.flip : dot_q[33];
	assign slot_free = !out_valid_q || pop;
	assign fifo_pop  = (state_q == B_IDLE) && !fifo_empty;

	assign empty       = !out_valid_q;
	assign quat_first  = out_q[0];
	assign quat_second = out_q[1];
	assign quat_third  = out_q[2];
	assign quat_fourth = out_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < 4; j++) begin
				prev_q[j] <= '0;
			end
		end else begin
			// A frame leaving the sign stage refills the slot on the same edge.
			if (pop && out_valid_q && state_q != B_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!fifo_empty) begin
						cur_q   <= fifo_frame;
						dot_q   <= '0;
						cnt_q   <= '0;
						state_q <= B_DOT;
					end
				end
				B_DOT: begin
					dot_q <= dot_q + 34'(dot_prod);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (slot_free) begin
						for (int j = 0; j < 4; j++) begin
							out_q[j]  <= negate ? 16'(16'sd0 - cur_comp[j]) : cur_comp[j];
							prev_q[j] <= negate ? 16'(16'sd0 - cur_comp[j]) : cur_comp[j];
						end
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else if (!pop) begin
						out_valid_q <= out_valid_q;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/quaternion_unpack_continuity.sv -----
// Compressed rotation frame decoder with sign continuity.
//
// Input side is a queue: drive the frame fields and push; a beat is taken at
// a clock edge where push is high and full is low. Result side is a queue as
// well: while empty is low the oldest decoded frame stands on quat_*, and it
// is taken at an edge where pop is high.
//
// The front rebuilds the missing component: three squares through one
// multiplier, then a digit-by-digit square root at one bit a cycle. This
// root loop sets the rate at which frames are accepted: the front takes no
// new frame until it has passed its finished frame to the queue. The back
// forms the dot product with the previous output, one component at a time,
// and fixes the sign.
//
// A two-entry queue separates front and back, the back holds one frame and
// the result register one more, so a stalled receiver first fills these;
// after that the front keeps its finished frame and full stays high until
// results move. Reset clears all queues and sets the previous frame to zero.
module quaternion_unpack_continuity (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] comp_a,
	input  logic signed [15:0] comp_b,
	input  logic signed [15:0] comp_c,
	input  logic               simple_mode,
	input  logic               first_of_track,
	input  logic               flip,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] quat_first,
	output logic signed [15:0] quat_second,
	output logic signed [15:0] quat_third,
	output logic signed [15:0] quat_fourth
);
	import qupk_pkg::*;

	qupk_frame_t front_frame;
	qupk_frame_t queue_frame;
	logic        front_valid;
	logic        queue_full;
	logic        queue_empty;
	logic        queue_pop;

	qupk_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.comp_a         (comp_a),
		.comp_b         (comp_b),
		.comp_c         (comp_c),
		.simple_mode    (simple_mode),
		.first_of_track (first_of_track),
		.flip           (flip),
		.frame_valid    (front_valid),
		.frame          (front_frame),
		.frame_ready    (!queue_full)
	);

	qupk_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_frame),
		.full    (queue_full),
		.rd_en   (queue_pop),
		.rd_data (queue_frame),
		.empty   (queue_empty)
	);

	qupk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (queue_empty),
		.fifo_frame  (queue_frame),
		.fifo_pop    (queue_pop),
		.empty       (empty),
		.pop         (pop),
		.quat_first  (quat_first),
		.quat_second (quat_second),
		.quat_third  (quat_third),
		.quat_fourth (quat_fourth)
	);

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	import qupk_pkg::ROOT_BASE;

	localparam longint NORM_SQ = longint'(ROOT_BASE);
	localparam int HOLD_CYCLES = 500;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int DIRECTED_ROWS = 18;

	typedef struct packed {
		logic signed [15:0] c0;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic signed [15:0] c3;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
		logic               simple;
		logic               track_start;
		logic               flip;
		logic               has_fixed;
		quat_t              fixed_quat;
	} frame_beat_t;

	typedef struct packed {
		int a;
		int b;
		int c;
		int simple;
		int track_start;
		int flip;
		int fixed_out;
		int e0;
		int e1;
		int e2;
		int e3;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [15:0] comp_a = '0;
	logic signed [15:0] comp_b = '0;
	logic signed [15:0] comp_c = '0;
	logic               simple_mode = 1'b0;
	logic               first_of_track = 1'b0;
	logic               flip = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] quat_first;
	logic signed [15:0] quat_second;
	logic signed [15:0] quat_third;
	logic signed [15:0] quat_fourth;

	frame_beat_t frames_to_send[$];
	quat_t       pending_quats[$];
	quat_t       last_output = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;

	logic signed [15:0] track_a = '0;
	logic signed [15:0] track_b = '0;
	logic signed [15:0] track_c = '0;

	// a, b, c, simple, track start, flip, fixed result, expected first..fourth
	table_row_t directed_table [0:DIRECTED_ROWS-1] = '{
		'{0, 0, 0, 1, 0, 0, 1, 0, 32767, 0, 0},                 // ahead of any track
		'{0, 0, 0, 0, 1, 1, 1, 0, 0, 0, -32767},                // track start, flipped
		'{-32768, -32768, -32768, 0, 1, 1, 1, -32768, -32768, -32768, 0},
		'{-32768, 0, 0, 1, 1, 0, 1, -32768, 0, 0, 0},           // radicand negative
		'{32767, 0, 0, 1, 1, 0, 1, 32767, 0, 0, 0},             // radicand exactly zero
		'{32767, 0, 0, 0, 0, 0, 1, 32767, 0, 0, 0},
		'{-1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},                 // opposite hemisphere
		'{0, 5, 0, 0, 0, 1, 0, 0, 0, 0, 0},                     // flip ignored mid-track
		'{32767, 32767, 32767, 0, 1, 0, 1, 32767, 32767, 32767, 0},
		'{32767, 32767, 32767, 0, 0, 1, 1, 32767, 32767, 32767, 0},
		'{-32768, -32768, -32768, 0, 0, 0, 1, -32768, -32768, -32768, 0},
		'{100, -200, 300, 1, 0, 0, 0, 0, 0, 0, 0},              // simple after full
		'{-1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{18918, 18918, 18918, 0, 1, 0, 0, 0, 0, 0, 0},         // small radicand
		'{16384, -16384, 16384, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 1, 1, 1, 1, 0, -32767, 0, 0},
		'{23170, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0}                  // root close to a half
	};

	quaternion_unpack_continuity dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.comp_a        (comp_a),
		.comp_b        (comp_b),
		.comp_c        (comp_c),
		.simple_mode   (simple_mode),
		.first_of_track(first_of_track),
		.flip          (flip),
		.empty         (empty),
		.pop           (pop),
		.quat_first    (quat_first),
		.quat_second   (quat_second),
		.quat_third    (quat_third),
		.quat_fourth   (quat_fourth)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] rounded_root(longint rad);
		longint lo;
		longint hi;
		longint mid;
		if (rad <= 0)
			return '0;
		// Keep lo*lo <= rad < hi*hi; the radicand stays below 2**30.
		lo = 0;
		hi = 32768;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= rad)
				lo = mid;
			else
				hi = mid;
		end
		if (rad - lo * lo > lo)
			lo = lo + 1;
		return 16'(lo);
	endfunction

	function automatic quat_t decode_frame(frame_beat_t f);
		quat_t  q;
		longint a2;
		longint dot;
		logic   turn;
		a2 = longint'($signed(f.a)) * longint'($signed(f.a));
		q.c0 = f.a;
		if (f.simple) begin
			q.c1 = rounded_root(NORM_SQ - a2);
			q.c2 = '0;
			q.c3 = '0;
		end else begin
			q.c1 = f.b;
			q.c2 = f.c;
			q.c3 = rounded_root(NORM_SQ - a2
				- longint'($signed(f.b)) * longint'($signed(f.b))
				- longint'($signed(f.c)) * longint'($signed(f.c)));
		end
		if (f.track_start) begin
			turn = f.flip;
		end else begin
			dot = longint'($signed(q.c0)) * longint'($signed(last_output.c0))
				+ longint'($signed(q.c1)) * longint'($signed(last_output.c1))
				+ longint'($signed(q.c2)) * longint'($signed(last_output.c2))
				+ longint'($signed(q.c3)) * longint'($signed(last_output.c3));
			turn = dot < 0;
		end
		if (turn) begin
			q.c0 = -q.c0;
			q.c1 = -q.c1;
			q.c2 = -q.c2;
			q.c3 = -q.c3;
		end
		last_output = q;
		return q;
	endfunction

	function automatic logic signed [15:0] nudge(logic signed [15:0] v);
		int t;
		t = int'(v) + int'($urandom_range(1200)) - 600;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return 16'(t);
	endfunction

	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return 16'shffff;
			3: return 16'sh0000;
			4: return 16'sh0001;
			default: return 16'sh7fff;
		endcase
	endfunction

	// Most frames drift from the previous one of the same track, sometimes with
	// the whole frame negated, so the hemisphere check sees both outcomes.
	function automatic frame_beat_t random_frame();
		frame_beat_t f;
		int pick;
		f = '0;
		pick = $urandom_range(99);
		f.simple = ($urandom_range(3) == 0);
		f.track_start = ($urandom_range(9) == 0);
		f.flip = 1'($urandom_range(1));
		if (pick < 60 && !f.track_start) begin
			f.a = nudge(track_a);
			f.b = nudge(track_b);
			f.c = nudge(track_c);
			if ($urandom_range(3) == 0) begin
				f.a = -f.a;
				f.b = -f.b;
				f.c = -f.c;
			end
		end else if (pick < 75) begin
			f.a = 16'($urandom);
			f.b = 16'($urandom);
			f.c = 16'($urandom);
		end else if (pick < 85) begin
			f.a = corner_value();
			f.b = corner_value();
			f.c = corner_value();
		end else begin
			// Roughly a unit rotation with a sizeable rebuilt component.
			f.a = 16'(int'($urandom_range(36000)) - 18000);
			f.b = 16'(int'($urandom_range(36000)) - 18000);
			f.c = 16'(int'($urandom_range(36000)) - 18000);
		end
		track_a = f.a;
		track_b = f.b;
		track_c = f.c;
		return f;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch: %s", what);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (frames_to_send.size() != 0 || pending_quats.size() != 0 || push);
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int count);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			frames_to_send.push_back(random_frame());
		wait_drained();
	endtask

	// Sender: a beat that is not taken stays on the ports unchanged.
	always @(posedge clk) begin
		frame_beat_t head;
		quat_t       want;
		if (arst_n && push && !full) begin
			head = frames_to_send[0];
			want = decode_frame(head);
			if (head.has_fixed)
				want = head.fixed_quat;
			pending_quats.push_back(want);
			void'(frames_to_send.pop_front());
		end
		if (push && full) begin
			push <= 1'b1;
		end else if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			head = frames_to_send[0];
			comp_a <= head.a;
			comp_b <= head.b;
			comp_c <= head.c;
			simple_mode <= head.simple;
			first_of_track <= head.track_start;
			flip <= head.flip;
			push <= 1'b1;
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: checks each beat taken and counts out its own long hold.
	always @(posedge clk) begin
		quat_t want;
		logic  hold_now;
		if (arst_n && pop && !empty) begin
			if (pending_quats.size() == 0) begin
				report_mismatch($sformatf("result %0d (%0d %0d %0d %0d) with none outstanding",
					results_seen, quat_first, quat_second, quat_third, quat_fourth));
			end else begin
				want = pending_quats.pop_front();
				if (quat_first !== want.c0)
					report_mismatch($sformatf("result %0d first: got %0d, want %0d",
						results_seen, quat_first, want.c0));
				if (quat_second !== want.c1)
					report_mismatch($sformatf("result %0d second: got %0d, want %0d",
						results_seen, quat_second, want.c1));
				if (quat_third !== want.c2)
					report_mismatch($sformatf("result %0d third: got %0d, want %0d",
						results_seen, quat_third, want.c2));
				if (quat_fourth !== want.c3)
					report_mismatch($sformatf("result %0d fourth: got %0d, want %0d",
						results_seen, quat_fourth, want.c3));
			end
			results_seen++;
		end
		hold_now = hold_req && !hold_seen;
		if (hold_now)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		hold_seen <= hold_req;
		pop <= !hold_now && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		frame_beat_t f;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			f.a = 16'(directed_table[i].a);
			f.b = 16'(directed_table[i].b);
			f.c = 16'(directed_table[i].c);
			f.simple = directed_table[i].simple != 0;
			f.track_start = directed_table[i].track_start != 0;
			f.flip = directed_table[i].flip != 0;
			f.has_fixed = directed_table[i].fixed_out != 0;
			f.fixed_quat.c0 = 16'(directed_table[i].e0);
			f.fixed_quat.c1 = 16'(directed_table[i].e1);
			f.fixed_quat.c2 = 16'(directed_table[i].e2);
			f.fixed_quat.c3 = 16'(directed_table[i].e3);
			frames_to_send.push_back(f);
		end
		wait_drained();

		run_phase(38, 81, 610);

		// Receiver holds off while the sender keeps offering beats until full.
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (24)
			frames_to_send.push_back(random_frame());
		wait_drained();
		hold_req = 1'b0;

		run_phase(81, 38, 610);
		run_phase(0, 0, 600);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/qupk_pkg.sv
hw/rtl/qupk_front.sv
hw/rtl/qupk_fifo.sv
hw/rtl/qupk_back.sv
hw/rtl/quaternion_unpack_continuity.sv
verif/tb_top.sv
